### src/lrc_pkg.sv
// ---------------------------------------------------------------------------
// lrc_pkg: shared types and constants of the LRU / random replacement cache
// Request and response codes, cell commands, the search chain word and the
// LFSR step function.
// ---------------------------------------------------------------------------
package lrc_pkg;

  // Fixed field widths of the request and response words.
  localparam int KeyBits     = 31;
  localparam int PayloadBits = 64;
  localparam int CountBits   = 5;
  localparam int AddrBits    = 3;
  localparam int ApbDataBits = 32;

  // Register index, taken from the word address bit.
  localparam logic RegPolicy = 1'b0;
  localparam logic RegSeed   = 1'b1;

  // Galois LFSR used for random eviction.
  localparam int          LfsrBits  = 16;
  localparam logic [15:0] LfsrTaps  = 16'hB400;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_MISS    = 2'd2
  } status_e;

  // Update that is broadcast to every cell in the apply cycle.
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_PROMOTE = 3'd1,
    OP_DROP    = 3'd2,
    OP_PUSH    = 3'd3,
    OP_CLEAR   = 3'd4
  } op_e;

  // Which of the cell's search flags marks the cell that the update targets.
  typedef enum logic [1:0] {
    TGT_HIT  = 2'd0,
    TGT_FREE = 2'd1,
    TGT_VICT = 2'd2
  } tgt_e;

  typedef struct packed {
    op_e  op;
    tgt_e tgt;
    logic load;
  } cmd_t;

  // Priority word handed from each cell to the next during the search.
  typedef struct packed {
    logic hit_seen;
    logic free_seen;
  } chain_t;

  function automatic logic [LfsrBits-1:0] lfsr_advance(input logic [LfsrBits-1:0] v);
    logic [LfsrBits-1:0] n;
    n = v >> 1;
    if (v[0]) begin
      n = n ^ LfsrTaps;
    end
    return n;
  endfunction

endpackage

### src/lrc_req_if.sv
// ---------------------------------------------------------------------------
// lrc_req_if: request channel of the cache
// Valid/ready channel that carries one request word.
// ---------------------------------------------------------------------------
interface lrc_req_if;
  logic                             valid;
  logic                             ready;
  lrc_pkg::action_e                 action;
  logic [lrc_pkg::KeyBits-1:0]      key;
  logic [lrc_pkg::PayloadBits-1:0]  payload;

  modport source (output valid, action, key, payload, input ready);
  modport sink   (input valid, action, key, payload, output ready);
endinterface

### src/lrc_rsp_if.sv
// ---------------------------------------------------------------------------
// lrc_rsp_if: response channel of the cache
// Valid/ready channel that carries one response word.
// ---------------------------------------------------------------------------
interface lrc_rsp_if;
  logic                             valid;
  logic                             ready;
  lrc_pkg::status_e                 status;
  logic [lrc_pkg::PayloadBits-1:0]  read_data;
  logic                             evicted;
  logic [lrc_pkg::KeyBits-1:0]      evicted_key;
  logic [lrc_pkg::CountBits-1:0]    entry_count;

  modport source (output valid, status, read_data, evicted, evicted_key, entry_count,
                  input ready);
  modport sink   (input valid, status, read_data, evicted, evicted_key, entry_count,
                  output ready);
endinterface

### src/lru_random_replacement_cache.sv
// A request is taken only when idle: the accept cycle runs the key search along the cell
// chain, and the apply state, once the response register is free, applies the update and
// loads that register. After reset, a seed write or a random eviction the LFSR remainder unit
// works out the quotient and then the remainder; no request is taken while it is busy.
// Reset (asynchronous, active low) empties all slots, sets the count to zero, selects LRU
// eviction and loads the LFSR with 1.
// ---------------------------------------------------------------------------
// lru_random_replacement_cache: fully associative cache, LRU or random eviction
// A row of slot cells searched by key, updated by a broadcast command, with
// an APB register port for the replacement policy and the LFSR seed.
// ---------------------------------------------------------------------------
module lru_random_replacement_cache #(
  parameter int ENTRIES   = 16,
  parameter int DATA_BITS = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lrc_req_if.sink                         req,
  lrc_rsp_if.source                       rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lrc_pkg::AddrBits-1:0]    paddr,
  input  logic [lrc_pkg::ApbDataBits-1:0] pwdata,
  output logic [lrc_pkg::ApbDataBits-1:0] prdata,
  output logic                            pready
);

  localparam int RankBits  = $clog2(ENTRIES);
  localparam int CountBits = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_APPLY = 2'b10
  } state_e;

  state_e                       state_q, state_d;
  logic                         policy_q;
  logic [lrc_pkg::LfsrBits-1:0] seed_q;
  logic [CountBits-1:0]         count_q, count_d;
  lrc_pkg::action_e             act_q;
  logic [lrc_pkg::KeyBits-1:0]  key_q;
  logic [DATA_BITS-1:0]         data_q;
  logic                         hit_any_q, full_q;

  logic                         cfg_wr;
  logic                         accept;
  logic                         out_free;
  logic                         apply;
  logic                         rnd_busy, rnd_step;
  logic [RankBits-1:0]          rnd_idx;
  lrc_pkg::cmd_t                cmd;
  logic [RankBits-1:0]          sel_rank;

  lrc_pkg::chain_t              chain     [ENTRIES+1];
  logic [RankBits-1:0]          hit_rank  [ENTRIES+1];
  logic [RankBits-1:0]          vic_rank  [ENTRIES+1];
  logic [DATA_BITS-1:0]         hit_data  [ENTRIES+1];
  logic [lrc_pkg::KeyBits-1:0]  vic_key   [ENTRIES+1];

  lrc_pkg::status_e             status_d;
  logic                         evicted_d;
  logic [lrc_pkg::KeyBits-1:0]  evicted_key_d;
  logic [DATA_BITS-1:0]         read_data_d;

  // Register port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= 1'b1;
      seed_q   <= lrc_pkg::LfsrBits'(1);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        lrc_pkg::RegPolicy: policy_q <= pwdata[0];
        lrc_pkg::RegSeed:   seed_q   <= pwdata[lrc_pkg::LfsrBits-1:0];
        default:            policy_q <= policy_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      lrc_pkg::RegPolicy: prdata = lrc_pkg::ApbDataBits'(policy_q);
      lrc_pkg::RegSeed:   prdata = lrc_pkg::ApbDataBits'(seed_q);
      default:            prdata = '0;
    endcase
  end

  // Random slot picker.
  lrc_rand #(
    .ENTRIES (ENTRIES)
  ) u_rand (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (cfg_wr && (paddr[2] == lrc_pkg::RegSeed)),
    .seed_i (pwdata[lrc_pkg::LfsrBits-1:0]),
    .step_i (rnd_step),
    .busy_o (rnd_busy),
    .idx_o  (rnd_idx)
  );

  // Handshakes.
  assign req.ready = (state_q == S_IDLE) && !rnd_busy;
  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;
  assign apply     = (state_q == S_APPLY) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_APPLY;
      S_APPLY: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Cell chain.
  assign chain[0]    = '0;
  assign hit_rank[0] = '0;
  assign vic_rank[0] = '0;
  assign hit_data[0] = '0;
  assign vic_key[0]  = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lrc_cell #(
      .ENTRIES   (ENTRIES),
      .DATA_BITS (DATA_BITS),
      .CELL_IDX  (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .look_i     (accept),
      .key_i      (req.key),
      .policy_i   (policy_q),
      .rnd_idx_i  (rnd_idx),
      .chain_i    (chain[i]),
      .chain_o    (chain[i+1]),
      .hit_rank_i (hit_rank[i]),
      .hit_rank_o (hit_rank[i+1]),
      .vic_rank_i (vic_rank[i]),
      .vic_rank_o (vic_rank[i+1]),
      .hit_data_i (hit_data[i]),
      .hit_data_o (hit_data[i+1]),
      .vic_key_i  (vic_key[i]),
      .vic_key_o  (vic_key[i+1]),
      .apply_i    (apply),
      .cmd_i      (cmd),
      .sel_rank_i (sel_rank),
      .new_key_i  (key_q),
      .new_data_i (data_q)
    );
  end

  // Request word and search summary, taken at the accept edge.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q     <= req.action;
      key_q     <= req.key;
      data_q    <= req.payload[DATA_BITS-1:0];
      hit_any_q <= chain[ENTRIES].hit_seen;
      full_q    <= (count_q == CountBits'(ENTRIES));
    end
  end

  // Update command and response fields.
  always_comb begin
    cmd           = '{op: lrc_pkg::OP_NONE, tgt: lrc_pkg::TGT_HIT, load: 1'b0};
    sel_rank      = hit_rank[ENTRIES];
    count_d       = count_q;
    status_d      = lrc_pkg::ST_OK;
    read_data_d   = '0;
    evicted_d     = 1'b0;
    evicted_key_d = '0;
    rnd_step      = 1'b0;
    case (act_q)
      lrc_pkg::ACT_LOOKUP: begin
        if (hit_any_q) begin
          cmd.op      = lrc_pkg::OP_PROMOTE;
          read_data_d = hit_data[ENTRIES];
        end else begin
          status_d = lrc_pkg::ST_MISS;
        end
      end
      lrc_pkg::ACT_INSERT: begin
        if (hit_any_q) begin
          cmd.op   = lrc_pkg::OP_PROMOTE;
          status_d = lrc_pkg::ST_PRESENT;
        end else if (full_q) begin
          // The victim's slot takes the new entry as most recent.
          cmd           = '{op: lrc_pkg::OP_PROMOTE, tgt: lrc_pkg::TGT_VICT, load: 1'b1};
          sel_rank      = vic_rank[ENTRIES];
          evicted_d     = 1'b1;
          evicted_key_d = vic_key[ENTRIES];
          rnd_step      = apply && !policy_q;
        end else begin
          cmd.op  = lrc_pkg::OP_PUSH;
          cmd.tgt = lrc_pkg::TGT_FREE;
          count_d = count_q + 1'b1;
        end
      end
      lrc_pkg::ACT_REMOVE: begin
        if (hit_any_q) begin
          cmd.op  = lrc_pkg::OP_DROP;
          count_d = count_q - 1'b1;
        end else begin
          status_d = lrc_pkg::ST_MISS;
        end
      end
      default: begin
        cmd.op  = lrc_pkg::OP_CLEAR;
        count_d = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (apply) begin
        count_q   <= count_d;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Response word register.
  always_ff @(posedge clk_i) begin
    if (apply) begin
      rsp.status      <= status_d;
      rsp.read_data   <= lrc_pkg::PayloadBits'(read_data_d);
      rsp.evicted     <= evicted_d;
      rsp.evicted_key <= evicted_key_d;
      rsp.entry_count <= lrc_pkg::CountBits'(count_d);
    end
  end

endmodule

### src/lrc_cell.sv
// ---------------------------------------------------------------------------
// lrc_cell: one slot of the cache
// Holds valid, key, data and recency rank of one slot, takes part in the
// priority search chain and applies the broadcast update.
// ---------------------------------------------------------------------------
module lrc_cell #(
  parameter int ENTRIES   = 16,
  parameter int DATA_BITS = 64,
  parameter int CELL_IDX  = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Search, sampled at the edge that accepts a request.
  input  logic                        look_i,
  input  logic [lrc_pkg::KeyBits-1:0] key_i,
  input  logic                        policy_i,
  input  logic [$clog2(ENTRIES)-1:0]  rnd_idx_i,
  input  lrc_pkg::chain_t             chain_i,
  output lrc_pkg::chain_t             chain_o,
  // Selected values, gathered along the chain in the apply cycle.
  input  logic [$clog2(ENTRIES)-1:0]  hit_rank_i,
  output logic [$clog2(ENTRIES)-1:0]  hit_rank_o,
  input  logic [$clog2(ENTRIES)-1:0]  vic_rank_i,
  output logic [$clog2(ENTRIES)-1:0]  vic_rank_o,
  input  logic [DATA_BITS-1:0]        hit_data_i,
  output logic [DATA_BITS-1:0]        hit_data_o,
  input  logic [lrc_pkg::KeyBits-1:0] vic_key_i,
  output logic [lrc_pkg::KeyBits-1:0] vic_key_o,
  // Update.
  input  logic                        apply_i,
  input  lrc_pkg::cmd_t               cmd_i,
  input  logic [$clog2(ENTRIES)-1:0]  sel_rank_i,
  input  logic [lrc_pkg::KeyBits-1:0] new_key_i,
  input  logic [DATA_BITS-1:0]        new_data_i
);

  localparam int RankBits = $clog2(ENTRIES);

  logic                        valid_q;
  logic [lrc_pkg::KeyBits-1:0] key_q;
  logic [DATA_BITS-1:0]        data_q;
  logic [RankBits-1:0]         rank_q;
  logic                        hit_q, free_q, vic_q;
  logic                        match;
  logic                        tgt;

  // Search: first matching slot, first free slot and the eviction victim.
  assign match = valid_q && (key_q == key_i);
  assign chain_o.hit_seen  = chain_i.hit_seen || match;
  assign chain_o.free_seen = chain_i.free_seen || !valid_q;

  always_ff @(posedge clk_i) begin
    if (look_i) begin
      hit_q  <= match && !chain_i.hit_seen;
      free_q <= !valid_q && !chain_i.free_seen;
      vic_q  <= valid_q && (policy_i ? (rank_q == RankBits'(ENTRIES - 1))
                                     : (rnd_idx_i == RankBits'(CELL_IDX)));
    end
  end

  // Gather the fields of the flagged slots.
  assign hit_rank_o = hit_rank_i | (hit_q ? rank_q : '0);
  assign vic_rank_o = vic_rank_i | (vic_q ? rank_q : '0);
  assign hit_data_o = hit_data_i | (hit_q ? data_q : '0);
  assign vic_key_o  = vic_key_i  | (vic_q ? key_q  : '0);

  // Target of the broadcast update.
  always_comb begin
    case (cmd_i.tgt)
      lrc_pkg::TGT_HIT:  tgt = hit_q;
      lrc_pkg::TGT_FREE: tgt = free_q;
      default:           tgt = vic_q;
    endcase
  end

  // Valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (apply_i) begin
      case (cmd_i.op)
        lrc_pkg::OP_DROP:  if (tgt) valid_q <= 1'b0;
        lrc_pkg::OP_PUSH:  if (tgt) valid_q <= 1'b1;
        lrc_pkg::OP_CLEAR: valid_q <= 1'b0;
        default:           valid_q <= valid_q;
      endcase
    end
  end

  // Key, data and recency rank.
  always_ff @(posedge clk_i) begin
    if (apply_i) begin
      case (cmd_i.op)
        lrc_pkg::OP_PROMOTE: begin
          if (tgt) begin
            rank_q <= '0;
            if (cmd_i.load) begin
              key_q  <= new_key_i;
              data_q <= new_data_i;
            end
          end else if (valid_q && rank_q < sel_rank_i) begin
            rank_q <= rank_q + 1'b1;
          end
        end
        lrc_pkg::OP_DROP: begin
          if (!tgt && valid_q && rank_q > sel_rank_i) begin
            rank_q <= rank_q - 1'b1;
          end
        end
        lrc_pkg::OP_PUSH: begin
          if (tgt) begin
            rank_q <= '0;
            key_q  <= new_key_i;
            data_q <= new_data_i;
          end else if (valid_q) begin
            rank_q <= rank_q + 1'b1;
          end
        end
        default: begin
          rank_q <= rank_q;
        end
      endcase
    end
  end

endmodule

### src/lrc_rand.sv
// ---------------------------------------------------------------------------
// lrc_rand: random slot picker
// Holds the LFSR and works out the slot index of its next value by reciprocal
// multiplication, first the quotient and then the remainder, so that the index is ready
// before the next eviction needs it.
// ---------------------------------------------------------------------------
module lrc_rand #(
  parameter int ENTRIES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic [lrc_pkg::LfsrBits-1:0] seed_i,
  input  logic                         step_i,
  output logic                         busy_o,
  output logic [$clog2(ENTRIES)-1:0]   idx_o
);

  localparam int IdxBits   = $clog2(ENTRIES);
  localparam int RecipBits = 32;
  localparam int ProdBits  = lrc_pkg::LfsrBits + RecipBits;
  // Scaled reciprocal of the slot count; the quotient is exact for every
  // 16-bit LFSR value because the rounding error stays below 1/ENTRIES.
  localparam logic [RecipBits-1:0] RecipMul =
      RecipBits'((64'd1 << RecipBits) / 64'(ENTRIES) + 64'd1);
  localparam logic [lrc_pkg::LfsrBits-1:0] SlotCount = lrc_pkg::LfsrBits'(ENTRIES);

  logic [lrc_pkg::LfsrBits-1:0] lfsr_q, nxt;
  logic [ProdBits-1:0]          prod;
  logic [lrc_pkg::LfsrBits-1:0] quo_q, quo_d;
  logic [lrc_pkg::LfsrBits-1:0] rem_full;
  logic [IdxBits-1:0]           rem_q;
  logic                         busy_q;
  logic                         stage_q;

  assign nxt = lrc_pkg::lfsr_advance(lfsr_q);

  // Quotient by reciprocal multiplication, then the remainder from it.
  assign prod     = ProdBits'(nxt) * ProdBits'(RecipMul);
  assign quo_d    = prod[ProdBits-1:RecipBits];
  assign rem_full = nxt - quo_q * SlotCount;

  // LFSR and remainder sequencing; a load or a step restarts the remainder.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q  <= lrc_pkg::LfsrBits'(1);
      busy_q  <= 1'b1;
      stage_q <= 1'b0;
      quo_q   <= '0;
      rem_q   <= '0;
    end else if (load_i || step_i) begin
      if (load_i) begin
        lfsr_q <= (seed_i == '0) ? lrc_pkg::LfsrBits'(1) : seed_i;
      end else begin
        lfsr_q <= nxt;
      end
      busy_q  <= 1'b1;
      stage_q <= 1'b0;
    end else if (busy_q) begin
      if (!stage_q) begin
        quo_q   <= quo_d;
        stage_q <= 1'b1;
      end else begin
        rem_q   <= rem_full[IdxBits-1:0];
        stage_q <= 1'b0;
        busy_q  <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign idx_o  = rem_q;

endmodule
